### design/lrk_pkg.sv
// ----------------------------------------------------------------------------
// lrk_pkg: shared types and constants for the LRU-K frame replacer
// Command codes, register index and the cell operation word.
// ----------------------------------------------------------------------------
package lrk_pkg;

  localparam logic [2:0] CMD_RECORD = 3'd0;
  localparam logic [2:0] CMD_SET_EV = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_EVICT  = 3'd3;
  localparam logic [2:0] CMD_SIZE   = 3'd4;

  localparam int unsigned REG_K_DEPTH = 0;
  localparam logic [3:0]  K_RESET     = 4'd2;

  typedef struct packed {
    logic cmd_record;
    logic cmd_set_ev;
    logic cmd_remove;
    logic clr;
    logic mark;
  } cell_op_t;

endpackage

### design/lru_k_frame_replacer.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer: LRU-K replacement over a fixed set of frames
// Command words come in on the input channel, one result word leaves per
// command on the output channel. k_depth lives at APB address 0.
// Record, set evictable, remove and size go through EXEC and OUT before
// out_valid_o rises; a new word is taken once the block is back in IDLE.
// Evict goes through EXEC, then SCAN, where a candidate word is pushed through
// a row of FRAME_CNT cells, one cell per cycle, then OUT like the others;
// frames with fewer than k stamps rank first by first stamp, others by their
// k-th most recent stamp, ties to the lowest frame.
// One command is in flight at a time; in_stall_o is high from accept until
// the result word moves into the output register.
// A stalled result holds its value in the output register while the next
// command runs; a second result waits in OUT until the first is taken.
// Reset empties every frame, zeroes the time and sets k_depth to 2.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer #(
  parameter int unsigned FRAME_CNT  = 16,
  parameter int unsigned K_MAX      = 8,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [$clog2(FRAME_CNT)-1:0]   frame_sel_i,
  input  logic        make_evictable_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [$clog2(FRAME_CNT)-1:0]   victim_frame_o,
  output logic [$clog2(FRAME_CNT+1)-1:0] evictable_count_o
);
  localparam int unsigned FW = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;
  localparam int unsigned CW = $clog2(K_MAX+1);
  localparam int unsigned NW = $clog2(FRAME_CNT+1);
  localparam int unsigned SW = $clog2(FRAME_CNT+2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_EXEC = 4'b0010, ST_SCAN = 4'b0100, ST_OUT = 4'b1000
  } state_e;

  state_e           state_q;
  logic [3:0]       k_q;
  logic [2:0]       cmd_q;
  logic [FW-1:0]    fid_q;
  logic             mark_q;
  logic [TIME_BITS-1:0] time_q;
  logic [NW-1:0]    total_q;
  logic [SW-1:0]    scan_q;
  logic             ok_q;
  logic [FW-1:0]    victim_q;
  logic             out_valid_q;
  logic             out_ok_q;
  logic [FW-1:0]    out_victim_q;
  logic [NW-1:0]    out_count_q;

  logic [CW-1:0]    k_eff;
  logic             in_range, sel_any;
  logic             acc, load_out;
  logic [FRAME_CNT-1:0] pres, evm, sel;
  lrk_pkg::cell_op_t op;

  logic                 cf [FRAME_CNT+1];
  logic                 cc [FRAME_CNT+1];
  logic [TIME_BITS-1:0] ct [FRAME_CNT+1];
  logic [FW-1:0]        ci [FRAME_CNT+1];

  assign pready = 1'b1;
  assign prdata = (paddr == 2'(lrk_pkg::REG_K_DEPTH)) ? {28'd0, k_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= lrk_pkg::K_RESET;
    end else if (psel && penable && pwrite && paddr == 2'(lrk_pkg::REG_K_DEPTH)) begin
      k_q <= pwdata[3:0];
    end
  end

  always_comb begin
    if (k_q == 4'd0) k_eff = CW'(1);
    else if (32'(k_q) > K_MAX) k_eff = CW'(K_MAX);
    else k_eff = CW'(k_q);
  end

  assign acc      = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_range = (32'(fid_q) < FRAME_CNT);
  assign sel_any  = in_range && pres[fid_q];
  assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    op.cmd_record = (state_q == ST_EXEC) && cmd_q == lrk_pkg::CMD_RECORD;
    op.cmd_set_ev = (state_q == ST_EXEC) && cmd_q == lrk_pkg::CMD_SET_EV;
    op.cmd_remove = (state_q == ST_EXEC) && cmd_q == lrk_pkg::CMD_REMOVE;
    op.mark       = mark_q;
    op.clr        = (op.cmd_remove && sel_any && evm[fid_q]) ||
                    ((state_q == ST_SCAN) && scan_q == SW'(FRAME_CNT) && cf[FRAME_CNT]);
    for (int i = 0; i < FRAME_CNT; i++) begin
      if (state_q == ST_SCAN) sel[i] = (ci[FRAME_CNT] == FW'(i));
      else sel[i] = in_range && (fid_q == FW'(i));
    end
  end

  assign cf[0] = 1'b0;
  assign cc[0] = 1'b0;
  assign ct[0] = '0;
  assign ci[0] = '0;

  for (genvar g = 0; g < FRAME_CNT; g++) begin : g_cell
    lrk_cell #(.KMax(K_MAX), .TimeBits(TIME_BITS), .FrameW(FW)) u_cell (
      .clk_i, .rst_ni,
      .sel_i(sel[g]), .op_i(op), .time_i(time_q), .k_i(k_eff), .idx_i(FW'(g)),
      .scan_i((state_q == ST_SCAN) && scan_q == SW'(g)),
      .c_found_i(cf[g]), .c_cls_i(cc[g]), .c_time_i(ct[g]), .c_idx_i(ci[g]),
      .c_found_o(cf[g+1]), .c_cls_o(cc[g+1]), .c_time_o(ct[g+1]), .c_idx_o(ci[g+1]),
      .present_o(pres[g]), .evict_o(evm[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q  <= command_i;
      fid_q  <= frame_sel_i;
      mark_q <= make_evictable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      time_q   <= '0;
      total_q  <= '0;
      scan_q   <= '0;
      ok_q     <= 1'b0;
      victim_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (acc) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          victim_q <= '0;
          case (cmd_q)
            lrk_pkg::CMD_RECORD: begin
              ok_q    <= in_range;
              state_q <= ST_OUT;
              if (in_range && time_q != '1) time_q <= time_q + 1'b1;
            end
            lrk_pkg::CMD_SET_EV: begin
              ok_q    <= sel_any;
              state_q <= ST_OUT;
              if (sel_any && evm[fid_q] != mark_q)
                total_q <= mark_q ? total_q + 1'b1 : total_q - 1'b1;
            end
            lrk_pkg::CMD_REMOVE: begin
              ok_q    <= sel_any && evm[fid_q];
              state_q <= ST_OUT;
              if (sel_any && evm[fid_q]) total_q <= total_q - 1'b1;
            end
            lrk_pkg::CMD_EVICT: begin
              ok_q    <= 1'b0;
              scan_q  <= '0;
              state_q <= ST_SCAN;
            end
            lrk_pkg::CMD_SIZE: begin
              ok_q    <= 1'b1;
              state_q <= ST_OUT;
            end
            default: begin
              ok_q    <= 1'b0;
              state_q <= ST_OUT;
            end
          endcase
        end
        ST_SCAN: begin
          if (scan_q == SW'(FRAME_CNT)) begin
            if (cf[FRAME_CNT]) begin
              ok_q     <= 1'b1;
              victim_q <= ci[FRAME_CNT];
              total_q  <= total_q - 1'b1;
            end
            state_q <= ST_OUT;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (load_out) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_ok_q     <= 1'b0;
      out_victim_q <= '0;
      out_count_q  <= '0;
    end else if (load_out) begin
      out_valid_q  <= 1'b1;
      out_ok_q     <= ok_q;
      out_victim_q <= victim_q;
      out_count_q  <= total_q;
    end else if (!out_stall_i) begin
      out_valid_q  <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign victim_frame_o    = out_victim_q;
  assign evictable_count_o = out_count_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(ok_o) &&
    $stable(victim_frame_o) && $stable(evictable_count_o)))
    else $error("stalled result changed");
  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> victim_frame_o == '0) else $error("victim without ok");
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= FRAME_CNT) else $error("evictable count overflow");
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> 32'(scan_q) <= FRAME_CNT) else $error("scan overrun");
endmodule

### design/lrk_cell.sv
// ----------------------------------------------------------------------------
// lrk_cell: one frame of the replacer
// Holds a frame's flags and stamp ring, and during evict compares its rank
// against the candidate handed in from the left neighbor.
// ----------------------------------------------------------------------------
module lrk_cell #(
  parameter int unsigned KMax     = 8,
  parameter int unsigned TimeBits = 32,
  parameter int unsigned FrameW   = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sel_i,
  input  lrk_pkg::cell_op_t            op_i,
  input  logic [TimeBits-1:0]          time_i,
  input  logic [$clog2(KMax+1)-1:0]    k_i,
  input  logic [FrameW-1:0]            idx_i,
  input  logic                         scan_i,
  input  logic                         c_found_i,
  input  logic                         c_cls_i,
  input  logic [TimeBits-1:0]          c_time_i,
  input  logic [FrameW-1:0]            c_idx_i,
  output logic                         c_found_o,
  output logic                         c_cls_o,
  output logic [TimeBits-1:0]          c_time_o,
  output logic [FrameW-1:0]            c_idx_o,
  output logic                         present_o,
  output logic                         evict_o
);
  localparam int unsigned HW = (KMax > 1) ? $clog2(KMax) : 1;
  localparam int unsigned CW = $clog2(KMax+1);

  logic               present_q, evict_q;
  logic [CW-1:0]      count_q;
  logic [HW-1:0]      head_q;
  logic [TimeBits-1:0] ring_q [KMax];

  logic               cls;
  logic [TimeBits-1:0] stamp;
  logic [HW:0]        pos;
  logic               better;

  always_comb begin
    pos = {1'b0, head_q} + (HW+1)'(KMax - 1) - {1'b0, k_i[HW-1:0]} + (HW+1)'(1);
    if (CW'(count_q) < k_i) begin
      cls   = 1'b0;
      stamp = ring_q[0];
    end else begin
      cls   = 1'b1;
      if (KMax == 1) stamp = ring_q[0];
      else if (pos >= (HW+1)'(KMax)) stamp = ring_q[HW'(pos - (HW+1)'(KMax))];
      else stamp = ring_q[pos[HW-1:0]];
    end
    better = present_q && evict_q &&
             (!c_found_i || (cls < c_cls_i) || (cls == c_cls_i && stamp < c_time_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      evict_q   <= 1'b0;
      count_q   <= '0;
      head_q    <= '0;
    end else if (op_i.clr && sel_i) begin
      present_q <= 1'b0;
      evict_q   <= 1'b0;
      count_q   <= '0;
      head_q    <= '0;
    end else if (sel_i && op_i.cmd_record) begin
      present_q <= 1'b1;
      if (!present_q) begin
        evict_q <= 1'b0;
        count_q <= CW'(1);
        head_q  <= (KMax > 1) ? HW'(1) : '0;
      end else begin
        if (count_q != CW'(KMax)) count_q <= count_q + CW'(1);
        head_q <= (KMax > 1 && head_q == HW'(KMax-1)) ? '0 :
                  (KMax > 1) ? head_q + HW'(1) : '0;
      end
    end else if (sel_i && op_i.cmd_set_ev && present_q) begin
      evict_q <= op_i.mark;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i && op_i.cmd_record && !op_i.clr) begin
      if (!present_q) ring_q[0] <= time_i;
      else ring_q[head_q] <= time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_found_o <= 1'b0;
      c_cls_o   <= 1'b0;
      c_time_o  <= '0;
      c_idx_o   <= '0;
    end else if (scan_i) begin
      c_found_o <= better | c_found_i;
      c_cls_o   <= better ? cls : c_cls_i;
      c_time_o  <= better ? stamp : c_time_i;
      c_idx_o   <= better ? idx_i : c_idx_i;
    end
  end

  assign present_o = present_q;
  assign evict_o   = evict_q;
endmodule

### tb/tb_lru_k_frame_replacer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_k_frame_replacer: self-checking bench for the LRU-K frame replacer
// Drives command words with random gaps and output stalls, predicts each
// result word from a local model of frames, stamps and k, and compares the
// words in order. k_depth is rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_lru_k_frame_replacer;

  localparam int unsigned NF = 16;
  localparam int unsigned KM = 8;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] frame_sel;
    logic       mark;
  } cmd_word_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] victim;
    logic [4:0] count;
  } res_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [3:0]  frame_sel_i = '0;
  logic        make_evictable_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [3:0]  victim_frame_o;
  logic [4:0]  evictable_count_o;

  lru_k_frame_replacer uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // replacer state mirror
  logic        m_present [NF];
  logic        m_evict   [NF];
  int unsigned m_count   [NF];
  logic [31:0] m_stamps  [NF][KM];
  int unsigned m_head    [NF];
  logic [31:0] m_time;
  int unsigned m_total;
  logic [3:0]  m_k;

  cmd_word_t   pending_words[$];
  res_word_t   expected_words[$];
  int unsigned errors = 0;
  int unsigned hold_cycles = 0;
  bit          rx_hold_en = 1'b1;

  function automatic void queue_cmd(cmd_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void queue_result(res_word_t r);
    expected_words.insert(expected_words.size(), r);
  endfunction

  function automatic void drop_frame(int unsigned f);
    m_present[f] = 1'b0;
    m_evict[f]   = 1'b0;
    m_count[f]   = 0;
    m_head[f]    = 0;
  endfunction

  function automatic res_word_t replace_step(cmd_word_t w);
    res_word_t   r;
    int unsigned f, k, cls, best, best_cls;
    logic [31:0] t, best_t;
    bit          found;
    r = '0;
    f = w.frame_sel;
    case (w.command)
      lrk_pkg::CMD_RECORD: begin
        if (!m_present[f]) drop_frame(f);
        m_present[f] = 1'b1;
        m_stamps[f][m_head[f]] = m_time;
        m_head[f] = (m_head[f] + 1) % KM;
        if (m_count[f] < KM) m_count[f]++;
        if (m_time != 32'hFFFF_FFFF) m_time++;
        r.ok = 1'b1;
      end
      lrk_pkg::CMD_SET_EV: begin
        if (m_present[f]) begin
          if (m_evict[f] != w.mark) begin
            m_evict[f] = w.mark;
            if (w.mark) m_total++;
            else m_total--;
          end
          r.ok = 1'b1;
        end
      end
      lrk_pkg::CMD_REMOVE: begin
        if (m_present[f] && m_evict[f]) begin
          drop_frame(f);
          m_total--;
          r.ok = 1'b1;
        end
      end
      lrk_pkg::CMD_EVICT: begin
        k = (m_k < 1) ? 1 : (m_k > KM) ? KM : m_k;
        found = 1'b0;
        best = 0;
        best_cls = 0;
        best_t = '0;
        for (int unsigned i = 0; i < NF; i++) begin
          if (m_present[i] && m_evict[i]) begin
            if (m_count[i] < k) begin
              cls = 0;
              t = m_stamps[i][0];
            end else begin
              cls = 1;
              t = m_stamps[i][(m_head[i] + KM - k) % KM];
            end
            if (!found || cls < best_cls || (cls == best_cls && t < best_t)) begin
              found = 1'b1;
              best = i;
              best_cls = cls;
              best_t = t;
            end
          end
        end
        if (found) begin
          drop_frame(best);
          m_total--;
          r.ok = 1'b1;
          r.victim = 4'(best);
        end
      end
      lrk_pkg::CMD_SIZE: r.ok = 1'b1;
      default: ;
    endcase
    r.count = 5'(m_total);
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int unsigned tx_gap = 0;
  bit          tx_pause = 1'b0;

  bit tx_accept;
  always @(posedge clk_i) tx_accept <= in_valid_i && !in_stall_o && rst_ni;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || tx_accept) begin
      if (tx_accept) queue_result(replace_step(pending_words.pop_front()));
      if (tx_gap > 0 || tx_pause || pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
        if (tx_gap > 0) tx_gap--;
      end else begin
        in_valid_i       <= 1'b1;
        command_i        <= pending_words[0].command;
        frame_sel_i      <= pending_words[0].frame_sel;
        make_evictable_i <= pending_words[0].mark;
        tx_gap           = gap_len();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (ok_o !== e.ok) begin
          $error("ok: expected %0d actual %0d", e.ok, ok_o);
          errors++;
        end
        if (victim_frame_o !== e.victim) begin
          $error("victim_frame: expected %0d actual %0d", e.victim, victim_frame_o);
          errors++;
        end
        if (evictable_count_o !== e.count) begin
          $error("evictable_count: expected %0d actual %0d", e.count, evictable_count_o);
          errors++;
        end
      end
    end
  end

  int unsigned rx_gap = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!rx_hold_en) begin
      out_stall_i <= 1'b0;
    end else if (rx_gap > 0) begin
      out_stall_i <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else begin
      out_stall_i <= 1'b0;
      rx_gap <= gap_len();
    end
  end

  task automatic apb_write(logic [3:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'(lrk_pkg::REG_K_DEPTH * 4);
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    m_k = value;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(negedge clk_i);
    repeat (NF + 8) @(negedge clk_i);
  endtask

  function automatic cmd_word_t rand_word(int unsigned hot);
    cmd_word_t   w;
    int unsigned p;
    p = $urandom_range(0, 99);
    w.frame_sel = (hot < 16) ? 4'($urandom_range(0, hot)) : 4'($urandom_range(0, 15));
    w.mark = 1'($urandom_range(0, 1));
    if (p < 40) w.command = lrk_pkg::CMD_RECORD;
    else if (p < 62) begin
      w.command = lrk_pkg::CMD_SET_EV;
      w.mark = ($urandom_range(0, 3) != 0);
    end
    else if (p < 72) w.command = lrk_pkg::CMD_REMOVE;
    else if (p < 90) w.command = lrk_pkg::CMD_EVICT;
    else if (p < 96) w.command = lrk_pkg::CMD_SIZE;
    else w.command = 3'($urandom_range(5, 7));
    return w;
  endfunction

  function automatic cmd_word_t mk(logic [2:0] c, logic [3:0] f, logic m);
    cmd_word_t w;
    w.command = c;
    w.frame_sel = f;
    w.mark = m;
    return w;
  endfunction

  initial begin
    logic [3:0] k_set [7] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2};
    for (int i = 0; i < NF; i++) drop_frame(i);
    m_time = '0;
    m_total = 0;
    m_k = lrk_pkg::K_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty evict, absent frames, all commands, extremes
    queue_cmd(mk(lrk_pkg::CMD_EVICT, 4'd0, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_SET_EV, 4'd15, 1'b1));
    queue_cmd(mk(lrk_pkg::CMD_REMOVE, 4'd0, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_RECORD, 4'd0, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_RECORD, 4'd15, 1'b1));
    queue_cmd(mk(lrk_pkg::CMD_REMOVE, 4'd0, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_SET_EV, 4'd0, 1'b1));
    queue_cmd(mk(lrk_pkg::CMD_SET_EV, 4'd0, 1'b1));
    queue_cmd(mk(lrk_pkg::CMD_SET_EV, 4'd15, 1'b1));
    queue_cmd(mk(lrk_pkg::CMD_RECORD, 4'd15, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_RECORD, 4'd15, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_SIZE, 4'd7, 1'b1));
    queue_cmd(mk(lrk_pkg::CMD_EVICT, 4'd0, 1'b0));
    queue_cmd(mk(3'd5, 4'd3, 1'b1));
    queue_cmd(mk(3'd7, 4'd15, 1'b0));
    queue_cmd(mk(3'd6, 4'd0, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_REMOVE, 4'd0, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_SET_EV, 4'd15, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_EVICT, 4'd0, 1'b0));
    queue_cmd(mk(lrk_pkg::CMD_SIZE, 4'd0, 1'b0));
    drain();

    foreach (k_set[p]) begin
      apb_write(k_set[p]);
      if (p == 1) begin
        rx_hold_en = 1'b0;
        hold_cycles = 400;
      end
      for (int n = 0; n < 220; n++)
        queue_cmd(rand_word((p % 2 == 0) ? 5 : 16));
      if (p == 3) begin
        while (pending_words.size() > 110) @(negedge clk_i);
        tx_pause = 1'b1;
        while (in_valid_i || expected_words.size() > 0) @(negedge clk_i);
        tx_pause = 1'b0;
      end
      drain();
      rx_hold_en = 1'b1;
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

### lru_k_frame_replacer.f
design/lrk_pkg.sv
design/lrk_cell.sv
design/lru_k_frame_replacer.sv
tb/tb_lru_k_frame_replacer.sv
